// ----- hw/rtl/fnp_pkg.sv -----
// Shared constants and tables for the nearest-point projection block.
package fnp_pkg;

   localparam int unsigned MaxPointsDefault   = 1024;
   localparam int unsigned CordicStepsDefault = 16;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic signed [31:0] CordicGain = 32'sd163008219;

   function automatic logic signed [31:0] atan_q32(input logic [4:0] idx);
      logic signed [31:0] r;
      case (idx)
         5'd0:  r = 32'sd536870912;
         5'd1:  r = 32'sd316933406;
         5'd2:  r = 32'sd167458907;
         5'd3:  r = 32'sd85004756;
         5'd4:  r = 32'sd42667331;
         5'd5:  r = 32'sd21354465;
         5'd6:  r = 32'sd10679838;
         5'd7:  r = 32'sd5340245;
         5'd8:  r = 32'sd2670163;
         5'd9:  r = 32'sd1335088;
         5'd10: r = 32'sd667544;
         5'd11: r = 32'sd333772;
         5'd12: r = 32'sd166886;
         5'd13: r = 32'sd83443;
         5'd14: r = 32'sd41722;
         5'd15: r = 32'sd20861;
         5'd16: r = 32'sd10430;
         5'd17: r = 32'sd5215;
         5'd18: r = 32'sd2608;
         5'd19: r = 32'sd1304;
         5'd20: r = 32'sd652;
         5'd21: r = 32'sd326;
         5'd22: r = 32'sd163;
         5'd23: r = 32'sd81;
         5'd24: r = 32'sd41;
         5'd25: r = 32'sd20;
         5'd26: r = 32'sd10;
         5'd27: r = 32'sd5;
         5'd28: r = 32'sd3;
         5'd29: r = 32'sd1;
         5'd30: r = 32'sd1;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/fnp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module fnp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/frenet_nearest_projection.sv -----
// Top level: reference point table, nearest-point scan and CORDIC lateral offset.
//
//  channel | dir | tdata fields (low bit up)                         | tuser
//  req_    | in  | op, pos_x, pos_y, station_in, heading_in (114->120) | -
//  rsp_    | out | status, station_out, lateral_out, closest_index    | -
//
// Clear and append are done on acceptance and leave the block ready. A query scans
// the table (read, difference, square and compare stages, one point per cycle),
// then runs the CORDIC rotation with winner load and fold-back, then the lateral
// product and rounding. Empty-table queries answer in the next cycle. Synchronous
// reset clears point count, overflow flag and the sequencer; the RAM is not
// cleared. req_tready is low from acceptance of a query until its result is taken
// and returns the cycle after; a stalled rsp_ transfer holds its data.
module frenet_nearest_projection #(
   parameter int unsigned MAX_POINTS   = fnp_pkg::MaxPointsDefault,
   parameter int unsigned CORDIC_STEPS = fnp_pkg::CordicStepsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // op, pos_x, pos_y, station_in, heading_in, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata   // status, station_out, lateral_out, closest_index, pad
);

   localparam int unsigned AW = $clog2(MAX_POINTS);
   localparam int unsigned CW = $clog2(MAX_POINTS + 1);
   localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_CORDIC, S_MUL1, S_MUL2, S_ROUND, S_OUT
   } state_type;

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic overflow_ff;
   logic signed [31:0] qx_ff, qy_ff;
   logic [CW-1:0] rd_ptr_ff, cmp_idx_ff;
   logic pipe_v_ff, pipe2_v_ff, pipe3_v_ff;
   logic [CW-1:0] pipe2_idx_ff, pipe3_idx_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [65:0] dist_ff;
   logic [65:0] best_dist_ff;
   logic [AW-1:0] best_ff;
   logic best_set_ff;
   logic signed [32:0] bdx_ff, bdy_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic flip_ff;
   logic [SW-1:0] step_ff;
   logic signed [63:0] p1_ff, acc_ff;
   logic [1:0] o_status_ff;
   logic [31:0] o_station_ff, o_lateral_ff;
   logic [9:0] o_index_ff;
   logic rsp_v_ff;

   logic [1:0] in_op;
   logic signed [31:0] in_x, in_y;
   logic [31:0] in_station;
   logic [15:0] in_heading;
   assign in_op      = req_tdata[1:0];
   assign in_x       = req_tdata[33:2];
   assign in_y       = req_tdata[65:34];
   assign in_station = req_tdata[97:66];
   assign in_heading = req_tdata[113:98];

   logic req_xfer, wr_en;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign wr_en      = req_xfer && in_op == fnp_pkg::OP_APPEND && count_ff < CW'(MAX_POINTS);

   logic [AW-1:0] rd_addr;
   logic [31:0] rd_x, rd_y, rd_st;
   logic [15:0] rd_h;
   assign rd_addr = (state_ff == S_SCAN && rd_ptr_ff < count_ff) ? rd_ptr_ff[AW-1:0]
                                                                 : best_ff;

   fnp_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (.clock, .wr_en,
      .wr_addr(count_ff[AW-1:0]), .wr_data(in_x), .rd_addr, .rd_data(rd_x));
   fnp_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (.clock, .wr_en,
      .wr_addr(count_ff[AW-1:0]), .wr_data(in_y), .rd_addr, .rd_data(rd_y));
   fnp_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_s (.clock, .wr_en,
      .wr_addr(count_ff[AW-1:0]), .wr_data(in_station), .rd_addr, .rd_data(rd_st));
   fnp_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ram_h (.clock, .wr_en,
      .wr_addr(count_ff[AW-1:0]), .wr_data(in_heading), .rd_addr, .rd_data(rd_h));

   logic signed [32:0] dx_in, dy_in;
   logic [32:0] ax, ay;
   logic [65:0] dist_in;
   assign dx_in   = 33'(qx_ff) - 33'(signed'(rd_x));
   assign dy_in   = 33'(qy_ff) - 33'(signed'(rd_y));
   assign ax      = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay      = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign dist_in = 66'(ax[31:0] * ax[31:0]) + 66'(ay[31:0] * ay[31:0])
                  + {ax[32], 65'd0} + {ay[32], 65'd0};

   logic signed [31:0] cz_init, xs, ys;
   logic signed [63:0] lat64;
   assign cz_init = signed'({rd_h, 16'd0});
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;
   assign lat64 = acc_ff + 64'sd134217728;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         rsp_v_ff    <= 1'b0;
         pipe_v_ff   <= 1'b0;
         pipe2_v_ff  <= 1'b0;
         pipe3_v_ff  <= 1'b0;
         best_set_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  case (in_op)
                     fnp_pkg::OP_CLEAR: begin
                        count_ff    <= '0;
                        overflow_ff <= 1'b0;
                     end
                     fnp_pkg::OP_APPEND: begin
                        if (wr_en) count_ff <= count_ff + 1'b1;
                        else overflow_ff <= 1'b1;
                     end
                     fnp_pkg::OP_QUERY: begin
                        qx_ff <= in_x;
                        qy_ff <= in_y;
                        if (count_ff == '0) begin
                           o_status_ff  <= fnp_pkg::ST_EMPTY;
                           o_station_ff <= '0;
                           o_lateral_ff <= '0;
                           o_index_ff   <= '0;
                           rsp_v_ff     <= 1'b1;
                           state_ff     <= S_OUT;
                        end else begin
                           rd_ptr_ff   <= '0;
                           pipe_v_ff   <= 1'b0;
                           pipe2_v_ff  <= 1'b0;
                           pipe3_v_ff  <= 1'b0;
                           best_set_ff <= 1'b0;
                           state_ff    <= S_SCAN;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_SCAN: begin
               // stage 0: RAM read, 1: differences, 2: squared distance, 3: compare
               pipe_v_ff <= rd_ptr_ff < count_ff;
               cmp_idx_ff <= rd_ptr_ff;
               if (rd_ptr_ff < count_ff) rd_ptr_ff <= rd_ptr_ff + 1'b1;
               dx_ff <= dx_in;
               dy_ff <= dy_in;
               pipe2_v_ff   <= pipe_v_ff;
               pipe2_idx_ff <= cmp_idx_ff;
               dist_ff      <= dist_in;
               pipe3_v_ff   <= pipe2_v_ff;
               pipe3_idx_ff <= pipe2_idx_ff;
               if (pipe3_v_ff && (!best_set_ff || dist_ff < best_dist_ff)) begin
                  best_dist_ff <= dist_ff;
                  best_ff      <= pipe3_idx_ff[AW-1:0];
                  best_set_ff  <= 1'b1;
               end
               if (rd_ptr_ff == count_ff && !pipe_v_ff && !pipe2_v_ff && !pipe3_v_ff) begin
                  state_ff    <= S_CORDIC;
                  step_ff     <= '0;
                  cx_ff       <= fnp_pkg::CordicGain;
                  cy_ff       <= '0;
                  best_set_ff <= 1'b1;
               end
            end
            S_CORDIC: begin
               if (best_set_ff) begin
                  // first cycle: RAM output holds the winner; load angle
                  best_set_ff <= 1'b0;
                  bdx_ff <= dx_in;
                  bdy_ff <= dy_in;
                  o_station_ff <= rd_st;
                  if (cz_init > 32'sd1073741824) begin
                     cz_ff <= cz_init - 32'sh80000000;
                     flip_ff <= 1'b1;
                  end else if (cz_init < -32'sd1073741824) begin
                     cz_ff <= cz_init + 32'sh80000000;
                     flip_ff <= 1'b1;
                  end else begin
                     cz_ff <= cz_init;
                     flip_ff <= 1'b0;
                  end
               end else if (step_ff < SW'(CORDIC_STEPS)) begin
                  if (!cz_ff[31]) begin
                     cx_ff <= cx_ff - ys;
                     cy_ff <= cy_ff + xs;
                     cz_ff <= cz_ff - fnp_pkg::atan_q32(5'(step_ff));
                  end else begin
                     cx_ff <= cx_ff + ys;
                     cy_ff <= cy_ff - xs;
                     cz_ff <= cz_ff + fnp_pkg::atan_q32(5'(step_ff));
                  end
                  step_ff <= step_ff + 1'b1;
               end else begin
                  if (flip_ff) begin
                     cx_ff <= -cx_ff;
                     cy_ff <= -cy_ff;
                  end
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: begin
               p1_ff    <= 64'(bdy_ff) * 64'(cx_ff);
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               acc_ff   <= p1_ff - 64'(bdx_ff) * 64'(cy_ff);
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               if (lat64 >>> 28 > 64'sd2147483647) o_lateral_ff <= 32'h7FFFFFFF;
               else if (lat64 >>> 28 < -64'sd2147483648) o_lateral_ff <= 32'h80000000;
               else o_lateral_ff <= lat64[59:28];
               o_status_ff <= overflow_ff ? fnp_pkg::ST_OVERFLOW : fnp_pkg::ST_OK;
               o_index_ff  <= 10'(best_ff);
               rsp_v_ff    <= 1'b1;
               state_ff    <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_v_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {4'd0, o_index_ff, o_lateral_ff, o_station_ff, o_status_ff};

`ifndef NO_ASSERTIONS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS)) else $error("point count beyond table");
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == S_OUT) else $error("result outside output state");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
`endif

endmodule
